/* design/rdd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Rice delta-list decoder.
// No dependencies; every other file of the block imports this package.
package rdd_pkg;

	localparam int KIND_W       = 2;
	localparam int BYTE_W       = 8;
	localparam int VALUE_W      = 32;
	localparam int K_W          = 5;
	localparam int ENTRY_W      = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int BIT_CNT_W    = 5;
	localparam int COUNT_BITS_DEF = 24;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RICE_K      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

	// Control from the sequencer to the bit decoder.
	typedef struct packed {
		logic bit_en;
		logic bit_in;
		logic clr;
		logic take;
	} bd_ctrl_t;

endpackage

/* design/rdd_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel of the Rice delta-list decoder.
// Depends on rdd_pkg.
interface rdd_cfg_if;
	import rdd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/rdd_in_if.sv */
`timescale 1ns / 1ps
// Input item channel of the Rice delta-list decoder.
// Depends on rdd_pkg.
interface rdd_in_if;
	import rdd_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

/* design/rdd_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the Rice delta-list decoder.
// Depends on rdd_pkg.
interface rdd_out_if;
	import rdd_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               error;
	logic               last;

	modport source (output valid, output value, output error, output last, input ready);
	modport sink (input valid, input value, input error, input last, output ready);
endinterface

/* design/rdd_bitdec.sv */
`timescale 1ns / 1ps
// Bit-serial Rice delta decoder: unary quotient, then k remainder bits, LSB first.
// Depends on rdd_pkg.
module rdd_bitdec (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdd_pkg::bd_ctrl_t           ctrl,
	input  logic [rdd_pkg::K_W-1:0]     k,
	output logic                        fin,
	output logic [rdd_pkg::VALUE_W-1:0] delta
);
	import rdd_pkg::*;

	logic               in_rem_q;
	logic [VALUE_W-1:0] quot_q;
	logic [VALUE_W-1:0] rem_q;
	logic [K_W-1:0]     seen_q;
	logic [VALUE_W-1:0] delta_q;
	logic [K_W-1:0]     seen_nxt;

	assign seen_nxt = seen_q + K_W'(1);

	// The remainder also ends when the bit counter wraps, which only matters
	// if the remainder width shrank while a delta was half read.
	always_comb begin
		fin = 1'b0;
		if (ctrl.bit_en) begin
			if (!in_rem_q)
				fin = !ctrl.bit_in && (k == '0);
			else
				fin = (seen_nxt >= k) || (seen_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rem_q <= 1'b0;
			quot_q   <= '0;
			rem_q    <= '0;
			seen_q   <= '0;
		end else if (ctrl.clr) begin
			in_rem_q <= 1'b0;
			quot_q   <= '0;
			rem_q    <= '0;
			seen_q   <= '0;
		end else if (ctrl.take) begin
			in_rem_q <= 1'b0;
			quot_q   <= '0;
			rem_q    <= '0;
			seen_q   <= '0;
		end else if (ctrl.bit_en) begin
			if (!in_rem_q) begin
				if (ctrl.bit_in)
					quot_q <= quot_q + VALUE_W'(1);
				else if (k != '0) begin
					in_rem_q <= 1'b1;
					rem_q    <= '0;
					seen_q   <= '0;
				end
			end else begin
				rem_q[seen_q] <= rem_q[seen_q] | ctrl.bit_in;
				seen_q        <= seen_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take)
			delta_q <= (quot_q << k) + rem_q;
	end

	assign delta = delta_q;

	// A finished delta is taken in the cycle right after it ends.
	a_fin_then_take: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> ctrl.take)
		else $error("finished delta not taken");

	// The decoder never works on a bit while it takes a delta.
	a_take_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.take && ctrl.bit_en))
		else $error("bit fed while a delta is taken");

endmodule

/* design/rice_delta_decoder.sv */
`timescale 1ns / 1ps
// Top level of the Rice-coded delta-list decoder: sequencer, registers, output slot.
// Depends on rdd_pkg, rdd_cfg_if, rdd_in_if, rdd_out_if and rdd_bitdec.
//
//   channel   role     payload                      handshake
//   cfg       sink     index, data                  valid / ready (always ready)
//   items     sink     kind, data_byte              valid / ready
//   results   source   value, error, last           valid / ready
//
// A data byte is accepted in idle; its eight bits then go one at a time, LSB first,
// through the bit decoder, and each delta that ends inside the byte passes the take and
// sum states. End of data feeds up to 24 zero padding bits the same way, then an error
// result. Results wait in a one-entry output register; a full register stalls the
// sequencer, not the bits already taken.
// Reset leaves the block idle with no list open.
module rice_delta_decoder #(
	parameter int COUNT_BITS = rdd_pkg::COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rdd_cfg_if.sink    cfg,
	rdd_in_if.sink     items,
	rdd_out_if.source  results
);
	import rdd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_BITS  = 3'd2;
	localparam logic [2:0] ST_DELTA = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;
	localparam logic [2:0] ST_ERR   = 3'd5;

	logic [2:0]            state_q;
	logic [K_W-1:0]        k_q;
	logic [VALUE_W-1:0]    first_q;
	logic [ENTRY_W-1:0]    count_q;
	logic [VALUE_W-1:0]    sum_q;
	logic [COUNT_BITS-1:0] entries_q;
	logic [1:0]            biw_q;
	logic                  done_q;
	logic                  end_q;
	logic [BYTE_W-1:0]     sr_q;
	logic [BIT_CNT_W-1:0]  bits_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_error_q;
	logic                  out_last_q;

	logic                  take_item;
	logic                  out_free;
	logic                  fin;
	logic [VALUE_W-1:0]    delta;
	logic [VALUE_W-1:0]    sum_next;
	logic [31:0]           count_ext;
	logic [COUNT_BITS-1:0] entries_load;
	logic [BIT_CNT_W-1:0]  pad_bits;
	bd_ctrl_t              bd_ctrl;

	logic                  push;
	logic [VALUE_W-1:0]    push_value;
	logic                  push_error;
	logic                  push_last;

	assign cfg.ready     = 1'b1;
	assign items.ready   = (state_q == ST_IDLE);
	assign take_item     = items.valid && (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || results.ready;
	assign sum_next      = sum_q + delta;
	assign count_ext     = {{(32 - ENTRY_W){1'b0}}, count_q};
	assign entries_load  = count_ext[COUNT_BITS-1:0];
	// Zero bits that pad the stream up to the next four-byte boundary.
	assign pad_bits      = {(2'd0 - biw_q), 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			first_q <= '0;
			count_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RICE_K:      k_q     <= cfg.data[K_W-1:0];
				REG_FIRST_VALUE: first_q <= cfg.data[VALUE_W-1:0];
				REG_ENTRY_COUNT: count_q <= cfg.data[ENTRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bd_ctrl.bit_en = (state_q == ST_BITS);
		bd_ctrl.bit_in = sr_q[0];
		bd_ctrl.clr    = take_item && (items.kind == KIND_START);
		bd_ctrl.take   = (state_q == ST_DELTA);
	end

	rdd_bitdec u_bitdec (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bd_ctrl),
		.k      (k_q),
		.fin    (fin),
		.delta  (delta)
	);

	always_comb begin
		push       = 1'b0;
		push_value = sum_next;
		push_error = 1'b0;
		push_last  = 1'b0;
		unique case (state_q)
			ST_START: begin
				push       = out_free;
				push_value = sum_q;
				push_last  = done_q;
			end
			ST_SUM: begin
				push      = out_free;
				push_last = (entries_q == '0);
			end
			ST_ERR: begin
				push       = out_free;
				push_value = '0;
				push_error = 1'b1;
				push_last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			entries_q <= '0;
			biw_q     <= '0;
			done_q    <= 1'b1;
			end_q     <= 1'b0;
			sr_q      <= '0;
			bits_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						unique case (items.kind)
							KIND_START: begin
								sum_q     <= first_q;
								entries_q <= entries_load;
								biw_q     <= '0;
								done_q    <= (entries_load == '0);
								end_q     <= 1'b0;
								state_q   <= ST_START;
							end
							KIND_DATA: begin
								if (!done_q) begin
									biw_q   <= biw_q + 2'd1;
									sr_q    <= items.data_byte;
									bits_q  <= BIT_CNT_W'(BYTE_W);
									end_q   <= 1'b0;
									state_q <= ST_BITS;
								end
							end
							KIND_END: begin
								if (!done_q) begin
									biw_q  <= '0;
									end_q  <= 1'b1;
									sr_q   <= '0;
									bits_q <= pad_bits;
									if (pad_bits == '0)
										state_q <= ST_ERR;
									else
										state_q <= ST_BITS;
								end
							end
							default: ;
						endcase
					end
				end
				ST_START: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_BITS: begin
					sr_q   <= sr_q >> 1;
					bits_q <= bits_q - BIT_CNT_W'(1);
					if (fin)
						state_q <= ST_DELTA;
					else if (bits_q == BIT_CNT_W'(1))
						state_q <= end_q ? ST_ERR : ST_IDLE;
				end
				ST_DELTA: begin
					entries_q <= entries_q - COUNT_BITS'(1);
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					if (out_free) begin
						sum_q <= sum_next;
						if (entries_q == '0) begin
							// List complete: the rest of the stream is ignored.
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else if (bits_q != '0)
							state_q <= ST_BITS;
						else
							state_q <= end_q ? ST_ERR : ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_value_q <= push_value;
			out_error_q <= push_error;
			out_last_q  <= push_last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = out_value_q;
	assign results.error = out_error_q;
	assign results.last  = out_last_q;

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || results.ready))
		else $error("result overwritten before it was taken");

	// A list that ends, with or without error, leaves the decoder closed.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_last) |=> done_q)
		else $error("list still open after its last result");

	// Bit cycles only run with bits left to decode.
	a_bits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BITS) |-> (bits_q != '0) && !done_q)
		else $error("bit cycle with no bits left or list closed");

	// An error result carries value zero and closes the list.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.error) |-> (results.last && (results.value == '0)))
		else $error("malformed error result");

endmodule
